@@ rtl/nnsa_pkg.sv @@
// ============================================================================
// nnsa_pkg
// Shared types and constants for the nearest-neighbor scale address generator.
// ============================================================================
package nnsa_pkg;

    // Size registers and internal positions / accumulators
    localparam int VAL_W     = 13;
    // Output coordinates
    localparam int OUT_W     = 12;
    // Configuration index width (covers indexes beyond the register list)
    localparam int CFG_IDX_W = 4;

    // Divider: one quotient bit per cycle
    localparam int DIV_STEPS = VAL_W;
    localparam int DIV_CNT_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 4'd3;

    // Register reset values
    localparam logic [VAL_W-1:0] SRC_WIDTH_RST  = 13'd640;
    localparam logic [VAL_W-1:0] SRC_HEIGHT_RST = 13'd480;
    localparam logic [VAL_W-1:0] DST_WIDTH_RST  = 13'd640;
    localparam logic [VAL_W-1:0] DST_HEIGHT_RST = 13'd480;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic div_start;   // start per-frame divisions
        logic load_frame;  // take quotients, zero positions, open frame
        logic emit;        // produce one result and step
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic frame_open;
        logic div_done;
    } status_t;

    // Size clamp: zero reads as one, anything above cap reads as cap
    function automatic logic [VAL_W-1:0] eff_size(input logic [VAL_W-1:0] v,
                                                  input logic [VAL_W-1:0] cap);
        logic [VAL_W-1:0] r;
        if (v == '0)
        begin
            r = {{(VAL_W-1){1'b0}}, 1'b1};
        end
        else if (v > cap)
        begin
            r = cap;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ rtl/nnsa_div.sv @@
// ============================================================================
// nnsa_div
// Iterative restoring divider, one quotient bit per cycle.
// ============================================================================
module nnsa_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nnsa_pkg::VAL_W-1:0]  dividend,
    input  logic [nnsa_pkg::VAL_W-1:0]  divisor,
    output logic                        done,
    output logic [nnsa_pkg::VAL_W-1:0]  quotient,
    output logic [nnsa_pkg::VAL_W-1:0]  remainder
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [nnsa_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [nnsa_pkg::VAL_W-1:0]     quo_reg, quo_next;
    logic [nnsa_pkg::VAL_W-1:0]     rem_reg, rem_next;
    logic [nnsa_pkg::VAL_W-1:0]     dvs_reg, dvs_next;

    logic [nnsa_pkg::VAL_W:0]       shifted;
    logic [nnsa_pkg::VAL_W:0]       diff;
    logic                           ge;

    assign shifted = {rem_reg, quo_reg[nnsa_pkg::VAL_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = nnsa_pkg::DIV_CNT_W'(nnsa_pkg::DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[nnsa_pkg::VAL_W-2:0], ge};
            rem_next = ge ? diff[nnsa_pkg::VAL_W-1:0] : shifted[nnsa_pkg::VAL_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == nnsa_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/nnsa_ctrl.sv @@
// ============================================================================
// nnsa_ctrl
// Sequencer: request acceptance, frame setup, output valid.
// ============================================================================
module nnsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_ready,
    input  nnsa_pkg::status_t  status,
    output nnsa_pkg::cmd_t     cmd
);

    nnsa_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;
    logic             new_frame;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == nnsa_pkg::ST_RUN) && out_free;
    assign accept    = in_valid && in_ready;
    assign new_frame = restart || !status.frame_open;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nnsa_pkg::ST_RUN:
            begin
                if (accept && new_frame)
                begin
                    state_next = nnsa_pkg::ST_DIV;
                end
            end
            nnsa_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = nnsa_pkg::ST_EMIT;
                end
            end
            nnsa_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = nnsa_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = nnsa_pkg::ST_RUN;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            nnsa_pkg::ST_RUN:
            begin
                cmd.div_start = accept && new_frame;
                cmd.emit      = accept && !new_frame;
            end
            nnsa_pkg::ST_DIV:
            begin
                cmd.load_frame = status.div_done;
            end
            nnsa_pkg::ST_EMIT:
            begin
                cmd.emit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nnsa_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/nnsa_dp.sv @@
// ============================================================================
// nnsa_dp
// Datapath: size registers, per-frame dividers, position stepping, results.
// ============================================================================
module nnsa_dp #(
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nnsa_pkg::cmd_t                  cmd,
    output nnsa_pkg::status_t               status,
    input  logic                            cfg_write,
    input  logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnsa_pkg::VAL_W-1:0]      cfg_data,
    output logic [nnsa_pkg::OUT_W-1:0]      src_col,
    output logic [nnsa_pkg::OUT_W-1:0]      src_row,
    output logic [nnsa_pkg::OUT_W-1:0]      dst_col,
    output logic [nnsa_pkg::OUT_W-1:0]      dst_row,
    output logic                            end_of_row,
    output logic                            end_of_frame
);

    localparam int SIZE_MAX = 1 << COORD_BITS;
    localparam int VAL_MAX  = (1 << nnsa_pkg::VAL_W) - 1;
    localparam int CAP_INT  = (SIZE_MAX > VAL_MAX) ? VAL_MAX : SIZE_MAX;
    localparam logic [nnsa_pkg::VAL_W-1:0] SIZE_CAP = nnsa_pkg::VAL_W'(CAP_INT);
    localparam logic [nnsa_pkg::OUT_W-1:0] OUT_MASK = nnsa_pkg::OUT_W'(SIZE_MAX - 1);

    localparam int W = nnsa_pkg::VAL_W;
    localparam int O = nnsa_pkg::OUT_W;

    // size registers
    logic [W-1:0] src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic         frame_open_reg;

    // frame state
    logic [W-1:0] col_pos_reg, row_pos_reg, col_error_reg, row_error_reg;
    logic [O-1:0] out_col_reg, out_row_reg;
    logic [W-1:0] col_step_whole_reg, col_step_rem_reg;
    logic [W-1:0] row_step_whole_reg, row_step_rem_reg;

    // result registers
    logic [O-1:0] src_col_reg, src_row_reg, dst_col_reg, dst_row_reg;
    logic         eor_reg, eof_reg;

    logic [W-1:0] sw, sh, dw, dh;
    logic         col_div_done, row_div_done;
    logic [W-1:0] col_quo, col_rem, row_quo, row_rem;

    logic         eor, eof;
    logic [W:0]   col_sum, row_sum;
    logic         col_wrap, row_wrap;
    logic [W-1:0] col_err_new, row_err_new;
    logic [W-1:0] col_pos_new, row_pos_new;

    assign sw = nnsa_pkg::eff_size(src_width_reg, SIZE_CAP);
    assign sh = nnsa_pkg::eff_size(src_height_reg, SIZE_CAP);
    assign dw = nnsa_pkg::eff_size(dst_width_reg, SIZE_CAP);
    assign dh = nnsa_pkg::eff_size(dst_height_reg, SIZE_CAP);

    nnsa_div u_col_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (sw),
        .divisor   (dw),
        .done      (col_div_done),
        .quotient  (col_quo),
        .remainder (col_rem)
    );

    nnsa_div u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (sh),
        .divisor   (dh),
        .done      (row_div_done),
        .quotient  (row_quo),
        .remainder (row_rem)
    );

    assign status.frame_open = frame_open_reg;
    assign status.div_done   = col_div_done && row_div_done;

    // end marks
    assign eor = {1'b0, out_col_reg} >= (dw - 1'b1);
    assign eof = eor && ({1'b0, out_row_reg} >= (dh - 1'b1));

    // error accumulators: extra step when remainder sum reaches the size
    assign col_sum     = {1'b0, col_error_reg} + {1'b0, col_step_rem_reg};
    assign col_wrap    = col_sum >= {1'b0, dw};
    assign col_err_new = col_wrap ? W'(col_sum - {1'b0, dw}) : col_sum[W-1:0];
    assign col_pos_new = col_pos_reg + col_step_whole_reg + {{(W-1){1'b0}}, col_wrap};

    assign row_sum     = {1'b0, row_error_reg} + {1'b0, row_step_rem_reg};
    assign row_wrap    = row_sum >= {1'b0, dh};
    assign row_err_new = row_wrap ? W'(row_sum - {1'b0, dh}) : row_sum[W-1:0];
    assign row_pos_new = row_pos_reg + row_step_whole_reg + {{(W-1){1'b0}}, row_wrap};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= nnsa_pkg::SRC_WIDTH_RST;
            src_height_reg <= nnsa_pkg::SRC_HEIGHT_RST;
            dst_width_reg  <= nnsa_pkg::DST_WIDTH_RST;
            dst_height_reg <= nnsa_pkg::DST_HEIGHT_RST;
            frame_open_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    nnsa_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                    nnsa_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                    nnsa_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                    nnsa_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                    default:                  ;
                endcase
                if (cfg_index == nnsa_pkg::REG_SRC_WIDTH ||
                    cfg_index == nnsa_pkg::REG_SRC_HEIGHT ||
                    cfg_index == nnsa_pkg::REG_DST_WIDTH ||
                    cfg_index == nnsa_pkg::REG_DST_HEIGHT)
                begin
                    frame_open_reg <= 1'b0;
                end
            end
            else if (cmd.load_frame)
            begin
                frame_open_reg <= 1'b1;
            end
            else if (cmd.emit && eof)
            begin
                frame_open_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_frame)
        begin
            col_step_whole_reg <= col_quo;
            col_step_rem_reg   <= col_rem;
            row_step_whole_reg <= row_quo;
            row_step_rem_reg   <= row_rem;
            col_pos_reg        <= '0;
            row_pos_reg        <= '0;
            col_error_reg      <= '0;
            row_error_reg      <= '0;
            out_col_reg        <= '0;
            out_row_reg        <= '0;
        end
        else if (cmd.emit)
        begin
            src_col_reg <= col_pos_reg[O-1:0] & OUT_MASK;
            src_row_reg <= row_pos_reg[O-1:0] & OUT_MASK;
            dst_col_reg <= out_col_reg & OUT_MASK;
            dst_row_reg <= out_row_reg & OUT_MASK;
            eor_reg     <= eor;
            eof_reg     <= eof;
            if (eof)
            begin
                // frame closes; next request reopens it
            end
            else if (eor)
            begin
                col_pos_reg   <= '0;
                col_error_reg <= '0;
                out_col_reg   <= '0;
                row_pos_reg   <= row_pos_new;
                row_error_reg <= row_err_new;
                out_row_reg   <= out_row_reg + 1'b1;
            end
            else
            begin
                col_pos_reg   <= col_pos_new;
                col_error_reg <= col_err_new;
                out_col_reg   <= out_col_reg + 1'b1;
            end
        end
    end

    assign src_col      = src_col_reg;
    assign src_row      = src_row_reg;
    assign dst_col      = dst_col_reg;
    assign dst_row      = dst_row_reg;
    assign end_of_row   = eor_reg;
    assign end_of_frame = eof_reg;

endmodule

@@ rtl/nearest_neighbor_scale_address.sv @@
// ============================================================================
// nearest_neighbor_scale_address
// Nearest-neighbor scaler address generator (top level).
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready, restart): each request asks for the next
//   destination pixel; restart=1 begins a new frame at pixel zero.
//   Output channel (out_valid/out_ready): one result per request with the
//   source column/row to copy, destination column/row, end-of-row and
//   end-of-frame marks.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): sizes, index
//   0..3 = src width, src height, dst width, dst height. Write only while idle.
//   Any size write closes the open frame; other indexes are ignored.
// Timing:
//   A request within an open frame: result registered when the request is
//   accepted, one request per cycle sustained while out_ready stays high.
//   A request that opens a frame (restart, after the last pixel, after reset
//   or a size write): the 13-step shift-subtract dividers run (one per axis,
//   in parallel), then the quotients are loaded and the result is registered.
// Reset: no frame open, sizes 640x480 -> 640x480, output empty.
// Stall: the output register holds its result while out_ready is low; a new
//   request is taken in the cycle the held result is taken.
// ============================================================================
module nearest_neighbor_scale_address #(
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [nnsa_pkg::OUT_W-1:0]      src_col,
    output logic [nnsa_pkg::OUT_W-1:0]      src_row,
    output logic [nnsa_pkg::OUT_W-1:0]      dst_col,
    output logic [nnsa_pkg::OUT_W-1:0]      dst_row,
    output logic                            end_of_row,
    output logic                            end_of_frame,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnsa_pkg::VAL_W-1:0]      cfg_data
);

    nnsa_pkg::cmd_t    cmd;
    nnsa_pkg::status_t status;

    // config writes are always accepted (cfg_ready held high)
    assign cfg_ready = 1'b1;

    nnsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nnsa_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .src_col      (src_col),
        .src_row      (src_row),
        .dst_col      (dst_col),
        .dst_row      (dst_row),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

`ifndef SYNTHESIS
    // a request is only taken when the output slot frees up
    a_accept_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_valid) |-> out_ready)
        else $error("request accepted while result stalled");

    // frame setup and pixel production are exclusive
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && (cmd.div_start || cmd.load_frame)))
        else $error("conflicting datapath commands");

    // loading a frame opens it unless a config write lands in the same cycle
    a_load_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_frame && !(cfg_valid && cfg_ready)) |=> status.frame_open)
        else $error("frame not open after load");

    // last pixel of frame is also last of its row
    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> end_of_row)
        else $error("end of frame without end of row");
`endif

endmodule
